// File: hw/rtl/media_player_button_controller_unit_macros.svh
// assertion helpers for the controller unit
`ifndef MEDIA_PLAYER_BUTTON_CONTROLLER_UNIT_MACROS_SVH
`define MEDIA_PLAYER_BUTTON_CONTROLLER_UNIT_MACROS_SVH

// clocked check, off while reset is high
`define MPBC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define MPBC_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/mpbc_pkg.sv
`timescale 1ns / 1ps

package mpbc_pkg;

  // player command codes
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_PLAY   = 3'd1,
    CMD_VOLUME = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4
  } cmd_t;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_MAX_TRACK  = 2'd0;
  localparam logic [1:0] REG_MAX_VOLUME = 2'd1;
  localparam logic [1:0] REG_LOCKOUT    = 2'd2;

  // register reset values
  localparam logic [7:0]  MAX_TRACK_RST  = 8'd16;
  localparam logic [5:0]  MAX_VOLUME_RST = 6'd30;
  localparam logic [15:0] LOCKOUT_RST    = 16'd200;

  // controller state reset values
  localparam logic [7:0] TRACK_RST  = 8'd1;
  localparam logic [5:0] VOLUME_RST = 6'd10;

  typedef struct packed {
    logic [7:0]  max_track;
    logic [5:0]  max_volume;
    logic [15:0] lockout_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  track_number;
    logic [5:0]  volume_level;
    logic        volume_mode;
    logic        paused_flag;
    logic        busy_before;
    logic [31:0] last_press_time;
  } state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        mode_pressed;
    logic        down_pressed;
    logic        up_pressed;
    logic        pause_pressed;
    logic        player_busy;
  } poll_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] argument;
    logic [7:0] current_track;
    logic [5:0] current_volume;
    logic       in_volume_mode;
    logic       is_paused;
    logic       last_of_run;
  } result_t;

endpackage

// File: hw/rtl/media_player_button_controller_unit.sv
`timescale 1ns / 1ps

// Button and auto-advance controller for a media player. Each request on the
// s_ side is one poll (time stamp, four button flags, busy flag); the block
// answers with one or two results on the m_ side, the last one marked by
// m_tlast. A poll sits in an input register while its single pass of
// next-state logic runs, and its results go into a two-entry result queue,
// so a new poll is taken every clock as long as each poll yields one result
// and m_tready stays high. A poll that yields two results (auto advance plus
// a button command) occupies the output for both, which then sets the rate.
// The first result passes through the input register and the result queue.
// Registers over APB: 0x0 max_track, 0x4 max_volume, 0x8 lockout_ms.

`include "media_player_button_controller_unit_macros.svh"

module media_player_button_controller_unit import mpbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // polls
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], mode_pressed[32], down_pressed[33], up_pressed[34],
  // pause_pressed[35], player_busy[36], zero[39:37]
  input  logic [39:0] s_tdata,
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // command[2:0], argument[10:3], current_track[18:11], current_volume[24:19],
  // in_volume_mode[25], is_paused[26], zero[31:27]
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  cfg_t       cfg;
  state_t     state;
  state_t     state_next;
  poll_t      poll;
  logic       poll_valid;
  result_t    res0;
  result_t    res1;
  result_t    head;
  logic       two;
  logic       room;
  logic       fire;
  logic       cfg_wr;
  logic [1:0] out_count;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_track  <= MAX_TRACK_RST;
      cfg.max_volume <= MAX_VOLUME_RST;
      cfg.lockout_ms <= LOCKOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_TRACK:  cfg.max_track  <= pwdata[7:0];
        REG_MAX_VOLUME: cfg.max_volume <= pwdata[5:0];
        REG_LOCKOUT:    cfg.lockout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_TRACK:  prdata = {24'd0, cfg.max_track};
      REG_MAX_VOLUME: prdata = {26'd0, cfg.max_volume};
      REG_LOCKOUT:    prdata = {16'd0, cfg.lockout_ms};
      default:        prdata = 32'd0;
    endcase
  end

  // input register
  assign fire     = poll_valid && room;
  assign s_tready = !poll_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (s_tready) begin
      poll_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      poll.now_ms        <= s_tdata[31:0];
      poll.mode_pressed  <= s_tdata[32];
      poll.down_pressed  <= s_tdata[33];
      poll.up_pressed    <= s_tdata[34];
      poll.pause_pressed <= s_tdata[35];
      poll.player_busy   <= s_tdata[36];
    end
  end

  // next-state and result logic
  mpbc_core u_core (
    .poll        (poll),
    .state       (state),
    .cfg         (cfg),
    .state_next  (state_next),
    .res0        (res0),
    .res1        (res1),
    .two_results (two)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.track_number    <= TRACK_RST;
      state.volume_level    <= VOLUME_RST;
      state.volume_mode     <= 1'b0;
      state.paused_flag     <= 1'b0;
      state.busy_before     <= 1'b0;
      state.last_press_time <= 32'd0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result queue
  mpbc_outbuf u_outbuf (
    .clk   (clk),
    .rst   (rst),
    .push  (fire),
    .two   (two),
    .res0  (res0),
    .res1  (res1),
    .room  (room),
    .valid (m_tvalid),
    .ready (m_tready),
    .head  (head),
    .count (out_count)
  );

  assign m_tdata = {5'd0, head.is_paused, head.in_volume_mode, head.current_volume,
                    head.current_track, head.argument, head.command};
  assign m_tlast = head.last_of_run;

  // checks
  `MPBC_CHECK(a_fire_gives_result, fire |=> m_tvalid, "accepted poll left no result")
  `MPBC_CHECK(a_state_only_on_fire, !fire |=> $stable(state), "state moved without a poll")
  `MPBC_CHECK(a_queue_bound, out_count != 2'd3, "result queue overfilled")

endmodule

// File: hw/rtl/mpbc_core.sv
`timescale 1ns / 1ps

module mpbc_core import mpbc_pkg::*; (
  input  poll_t   poll,
  input  state_t  state,
  input  cfg_t    cfg,
  output state_t  state_next,
  output result_t res0,
  output result_t res1,
  output logic    two_results
);

  logic [31:0] diff_mode;
  logic [31:0] diff_btn;
  logic [31:0] lockout_ext;
  logic        mode_ok;
  logic        btn_ok;
  logic        vmode1;
  logic [31:0] press1;
  logic        advance;
  logic [7:0]  track1;
  logic [7:0]  track2;
  logic [5:0]  volume2;
  logic        paused2;
  logic        btn_emit;
  cmd_t        btn_cmd;
  logic [7:0]  btn_arg;
  logic [31:0] press2;
  logic        busy2;

  // step forward with wrap to one
  function automatic logic [7:0] track_up(input logic [7:0] t, input logic [7:0] mx);
    logic [7:0] r;
    r = (t >= mx) ? 8'd1 : t + 8'd1;
    return r;
  endfunction

  // step back with wrap to the highest track
  function automatic logic [7:0] track_down(input logic [7:0] t, input logic [7:0] mx);
    logic [7:0] r;
    r = (t <= 8'd1) ? mx : t - 8'd1;
    return r;
  endfunction

  // mode press, checked against the old press time
  always_comb begin
    lockout_ext = {16'd0, cfg.lockout_ms};
    diff_mode   = poll.now_ms - state.last_press_time;
    mode_ok     = poll.mode_pressed && (diff_mode > lockout_ext);
    vmode1      = mode_ok ? ~state.volume_mode : state.volume_mode;
    press1      = mode_ok ? poll.now_ms : state.last_press_time;
  end

  // auto advance on falling busy in track mode while playing
  always_comb begin
    advance = 1'b0;
    busy2   = state.busy_before;
    if (!vmode1 && !state.paused_flag) begin
      advance = state.busy_before && !poll.player_busy;
      busy2   = poll.player_busy;
    end
    track1 = advance ? track_up(state.track_number, cfg.max_track) : state.track_number;
  end

  // other buttons, down over up over pause
  always_comb begin
    diff_btn = poll.now_ms - press1;
    btn_ok   = diff_btn >= lockout_ext;
    track2   = track1;
    volume2  = state.volume_level;
    paused2  = state.paused_flag;
    btn_emit = 1'b0;
    btn_cmd  = CMD_NONE;
    btn_arg  = 8'd0;
    press2   = press1;
    if (btn_ok) begin
      priority if (poll.down_pressed) begin
        press2 = poll.now_ms;
        if (vmode1) begin
          if (state.volume_level != 6'd0) begin
            volume2  = state.volume_level - 6'd1;
            btn_emit = 1'b1;
            btn_cmd  = CMD_VOLUME;
            btn_arg  = {2'b00, volume2};
          end
        end else begin
          track2   = track_down(track1, cfg.max_track);
          paused2  = 1'b0;
          btn_emit = 1'b1;
          btn_cmd  = CMD_PLAY;
          btn_arg  = track2;
        end
      end else if (poll.up_pressed) begin
        press2 = poll.now_ms;
        if (vmode1) begin
          if (state.volume_level < cfg.max_volume) begin
            volume2  = state.volume_level + 6'd1;
            btn_emit = 1'b1;
            btn_cmd  = CMD_VOLUME;
            btn_arg  = {2'b00, volume2};
          end
        end else begin
          track2   = track_up(track1, cfg.max_track);
          paused2  = 1'b0;
          btn_emit = 1'b1;
          btn_cmd  = CMD_PLAY;
          btn_arg  = track2;
        end
      end else if (poll.pause_pressed) begin
        press2   = poll.now_ms;
        paused2  = ~state.paused_flag;
        btn_emit = 1'b1;
        btn_cmd  = paused2 ? CMD_PAUSE : CMD_RESUME;
      end else begin
        // no button held, press time stays
        press2 = press1;
      end
    end
  end

  // next state
  always_comb begin
    state_next.track_number    = track2;
    state_next.volume_level    = volume2;
    state_next.volume_mode     = vmode1;
    state_next.paused_flag     = paused2;
    state_next.busy_before     = busy2;
    state_next.last_press_time = press2;
  end

  // results: auto advance first, then the button command, or one empty result
  always_comb begin
    two_results = advance && btn_emit;
    res1.command        = btn_cmd;
    res1.argument       = btn_arg;
    res1.current_track  = track2;
    res1.current_volume = volume2;
    res1.in_volume_mode = vmode1;
    res1.is_paused      = paused2;
    res1.last_of_run    = 1'b1;
    if (advance) begin
      res0.command        = CMD_PLAY;
      res0.argument       = track1;
      res0.current_track  = track1;
      res0.current_volume = state.volume_level;
      res0.in_volume_mode = vmode1;
      res0.is_paused      = state.paused_flag;
      res0.last_of_run    = !btn_emit;
    end else begin
      res0 = res1;
    end
  end

endmodule

// File: hw/rtl/mpbc_outbuf.sv
`timescale 1ns / 1ps

module mpbc_outbuf import mpbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    two,
  input  result_t res0,
  input  result_t res1,
  output logic    room,
  output logic    valid,
  input  logic    ready,
  output result_t head,
  output logic [1:0] count
);

  result_t    slot0;
  result_t    slot1;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] base;
  logic       pop;

  assign valid = (cnt != 2'd0);
  assign head  = slot0;
  assign count = cnt;
  assign pop   = valid && ready;
  assign base  = cnt - {1'b0, pop};

  // room for this request's results once the head leaves
  assign room = (base == 2'd0) || ((base == 2'd1) && !two);

  always_comb begin
    cnt_next = base;
    if (push) begin
      cnt_next = base + (two ? 2'd2 : 2'd1);
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // two-entry queue, shifts toward the head on a pop
  always_ff @(posedge clk) begin
    if (push && (base == 2'd0)) begin
      slot0 <= res0;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && (base == 2'd0) && two) begin
      slot1 <= res1;
    end else if (push && (base == 2'd1)) begin
      slot1 <= res0;
    end
  end

endmodule

// File: tb/sv/tb_media_player_button_controller_unit.sv
`timescale 1ns / 1ps

module tb_media_player_button_controller_unit;
  import mpbc_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // now_ms[31:0], mode_pressed[32], down_pressed[33], up_pressed[34],
  // pause_pressed[35], player_busy[36], zero[39:37]
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // command[2:0], argument[10:3], current_track[18:11], current_volume[24:19],
  // in_volume_mode[25], is_paused[26], zero[31:27]
  logic [31:0] m_tdata;
  logic        m_tlast;

  // predicted register copy
  logic [7:0]  cfg_max_track = MAX_TRACK_RST;
  logic [5:0]  cfg_max_volume = MAX_VOLUME_RST;
  logic [15:0] cfg_lockout = LOCKOUT_RST;

  // predicted player state
  logic [7:0]  pl_track = TRACK_RST;
  logic [5:0]  pl_volume = VOLUME_RST;
  logic        pl_volume_mode = 1'b0;
  logic        pl_paused = 1'b0;
  logic        pl_busy_q = 1'b0;
  logic [31:0] pl_last_press = '0;

  result_t     expected_cmds[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          stall_count = 0;
  int          stall_style = 0;
  logic [31:0] sim_now = '0;
  logic        busy_level = 1'b0;

  media_player_button_controller_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // track after the current one, wrapping to one
  function automatic logic [7:0] next_track();
    return (pl_track >= cfg_max_track) ? 8'd1 : pl_track + 8'd1;
  endfunction

  function automatic result_t player_result(cmd_t cmd, logic [7:0] arg);
    result_t r;
    r.command        = cmd;
    r.argument       = arg;
    r.current_track  = pl_track;
    r.current_volume = pl_volume;
    r.in_volume_mode = pl_volume_mode;
    r.is_paused      = pl_paused;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // player commands caused by one poll
  task automatic predict_player_response(input poll_t pl);
    result_t     outs[2];
    int          n;
    logic [31:0] gap;
    n = 0;
    gap = pl.now_ms - pl_last_press;
    // mode press needs strictly more than the lockout
    if (pl.mode_pressed && gap > {16'd0, cfg_lockout}) begin
      pl_volume_mode = ~pl_volume_mode;
      pl_last_press = pl.now_ms;
    end
    // auto advance on falling busy
    if (!pl_volume_mode && !pl_paused) begin
      if (pl_busy_q && !pl.player_busy) begin
        pl_track = next_track();
        outs[n] = player_result(CMD_PLAY, pl_track);
        n++;
      end
      pl_busy_q = pl.player_busy;
    end
    // one of down, up, pause in priority order
    gap = pl.now_ms - pl_last_press;
    if (gap >= {16'd0, cfg_lockout}) begin
      if (pl.down_pressed) begin
        if (pl_volume_mode) begin
          if (pl_volume > 6'd0) begin
            pl_volume = pl_volume - 6'd1;
            outs[n] = player_result(CMD_VOLUME, {2'b00, pl_volume});
            n++;
          end
        end else begin
          pl_track = (pl_track <= 8'd1) ? cfg_max_track : pl_track - 8'd1;
          pl_paused = 1'b0;
          outs[n] = player_result(CMD_PLAY, pl_track);
          n++;
        end
        pl_last_press = pl.now_ms;
      end else if (pl.up_pressed) begin
        if (pl_volume_mode) begin
          if (pl_volume < cfg_max_volume) begin
            pl_volume = pl_volume + 6'd1;
            outs[n] = player_result(CMD_VOLUME, {2'b00, pl_volume});
            n++;
          end
        end else begin
          pl_track = next_track();
          pl_paused = 1'b0;
          outs[n] = player_result(CMD_PLAY, pl_track);
          n++;
        end
        pl_last_press = pl.now_ms;
      end else if (pl.pause_pressed) begin
        pl_paused = ~pl_paused;
        outs[n] = player_result(pl_paused ? CMD_PAUSE : CMD_RESUME, 8'd0);
        n++;
        pl_last_press = pl.now_ms;
      end
    end
    if (n == 0) begin
      outs[0] = player_result(CMD_NONE, 8'd0);
      n = 1;
    end
    outs[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_cmds.push_back(outs[i]);
  endtask

  // predict every accepted poll
  always @(posedge clk) begin : poll_monitor
    poll_t seen;
    if (!rst && s_tvalid && s_tready) begin
      seen.now_ms        = s_tdata[31:0];
      seen.mode_pressed  = s_tdata[32];
      seen.down_pressed  = s_tdata[33];
      seen.up_pressed    = s_tdata[34];
      seen.pause_pressed = s_tdata[35];
      seen.player_busy   = s_tdata[36];
      predict_player_response(seen);
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = expected_cmds.pop_front();
        report_field("command", want.command, m_tdata[2:0]);
        report_field("argument", want.argument, m_tdata[10:3]);
        report_field("current_track", want.current_track, m_tdata[18:11]);
        report_field("current_volume", want.current_volume, m_tdata[24:19]);
        report_field("in_volume_mode", want.in_volume_mode, m_tdata[25]);
        report_field("is_paused", want.is_paused, m_tdata[26]);
        report_field("last_of_run", want.last_of_run, m_tlast);
      end
    end
  end

  // receiver stall pattern, style picked anew whenever the stall counter runs out
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_count <= $urandom_range(20, 80);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_style)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_tready <= (stall_count % 4 == 0);
      end
    endcase
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL media_player_button_controller_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one poll request, sent in bursts with random gaps
  task automatic send_poll(input logic [31:0] t, input logic mode_b, input logic down_b,
                           input logic up_b, input logic pause_b, input logic busy_b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, busy_b, pause_b, up_b, down_b, mode_b, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // stop sending and let all results come out
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MAX_TRACK:  cfg_max_track = value[7:0];
      REG_MAX_VOLUME: cfg_max_volume = value[5:0];
      REG_LOCKOUT:    cfg_lockout = value[15:0];
      default: ;
    endcase
    // leave the bus idle between writes
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] mt, input logic [5:0] mv, input logic [15:0] lo);
    drain();
    write_reg(REG_MAX_TRACK, {24'd0, mt});
    write_reg(REG_MAX_VOLUME, {26'd0, mv});
    write_reg(REG_LOCKOUT, {16'd0, lo});
  endtask

  // buttons, lockout edges, auto advance and time wrap at reset settings
  task automatic test_button_controls();
    send_poll(32'd0, 0, 0, 0, 0, 0);
    send_poll(32'd100, 0, 0, 1, 0, 0);
    send_poll(32'd200, 1, 0, 1, 0, 0);
    send_poll(32'd300, 0, 0, 0, 0, 1);
    send_poll(32'd350, 0, 0, 0, 0, 0);
    send_poll(32'd351, 0, 0, 0, 0, 1);
    send_poll(32'd600, 0, 0, 1, 0, 0);
    send_poll(32'd800, 0, 1, 0, 0, 0);
    send_poll(32'd1000, 0, 0, 0, 1, 1);
    send_poll(32'd1001, 0, 0, 0, 0, 0);
    send_poll(32'd1300, 0, 0, 1, 0, 0);
    send_poll(32'd1500, 1, 0, 0, 0, 1);
    send_poll(32'd1501, 0, 0, 0, 0, 0);
    send_poll(32'd1800, 0, 0, 1, 0, 0);
    send_poll(32'd2100, 0, 1, 1, 1, 0);
    send_poll(32'd2400, 0, 0, 0, 1, 0);
    send_poll(32'hFFFF_FF00, 0, 0, 1, 0, 0);
    send_poll(32'h0000_0010, 1, 0, 0, 0, 0);
  endtask

  // volume clamps, track wrap and lockout at register extremes
  task automatic test_limits_and_wrap();
    set_config(8'd255, 6'd0, 16'd0);
    send_poll(32'd100, 1, 0, 0, 0, 0);
    repeat (12) send_poll(32'd100, 0, 1, 0, 0, 0);
    send_poll(32'd100, 0, 0, 1, 0, 0);
    send_poll(32'd101, 1, 0, 0, 0, 0);
    set_config(8'd1, 6'd63, 16'd0);
    send_poll(32'd102, 0, 0, 1, 0, 0);
    send_poll(32'd102, 0, 1, 0, 0, 0);
    set_config(8'd255, 6'd63, 16'd0);
    send_poll(32'd103, 0, 1, 0, 0, 0);
    send_poll(32'd103, 0, 0, 1, 0, 0);
    set_config(8'd0, 6'd63, 16'd0);
    send_poll(32'd104, 0, 0, 1, 0, 0);
    send_poll(32'd104, 0, 1, 0, 0, 0);
    send_poll(32'd104, 0, 0, 1, 0, 0);
    set_config(8'd16, 6'd63, 16'd65535);
    send_poll(32'd200000, 0, 0, 1, 0, 0);
    send_poll(32'd265534, 0, 0, 1, 0, 0);
    send_poll(32'd265535, 1, 0, 1, 0, 0);
    send_poll(32'd331071, 1, 0, 0, 0, 0);
    sim_now = 32'd331071;
  endtask

  // random polls with moving time, button presses and busy edges
  task automatic test_random_polls(input logic [7:0] mt, input logic [5:0] mv,
                                   input logic [15:0] lo, input int count);
    int          roll;
    logic [31:0] step;
    set_config(mt, mv, lo);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) step = $urandom_range(0, lo);
      else if (roll < 40) step = lo + $urandom_range(0, 1);
      else if (roll < 95) step = lo + $urandom_range(2, 2 * lo + 40);
      else step = $urandom();
      sim_now = sim_now + step;
      if ($urandom_range(0, 2) == 0) busy_level = ~busy_level;
      send_poll(sim_now, $urandom_range(0, 5) == 0, $urandom_range(0, 4) == 0,
                $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, busy_level);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_button_controls();
    test_limits_and_wrap();
    test_random_polls(8'd255, 6'd63, 16'd65535, 150);
    test_random_polls(8'd1, 6'd0, 16'd0, 150);
    test_random_polls(8'($urandom_range(1, 255)), 6'($urandom_range(0, 63)),
                      16'($urandom_range(0, 65535)), 150);
    test_random_polls(8'd3, 6'd5, 16'd20, 150);
    test_random_polls(8'($urandom_range(1, 255)), 6'($urandom_range(0, 63)),
                      16'($urandom_range(0, 500)), 150);
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("PASS media_player_button_controller_unit");
    end else begin
      $display("FAIL media_player_button_controller_unit");
    end
    $finish;
  end

endmodule
